// File: rtl/core/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Status codes, pad character and the per-item result bundle of the decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_BAD_CHAR      = 3'd1;
    localparam logic [2:0] ST_MISPLACED_PAD = 3'd2;
    localparam logic [2:0] ST_TOO_MUCH_PAD  = 3'd3;
    localparam logic [2:0] ST_TRAIL_BITS    = 3'd4;
    localparam logic [2:0] ST_BAD_LENGTH    = 3'd5;

    // All results caused by one input item; byte k goes out k-th.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            has_data;
        logic            eom;
        logic [2:0]      status;
    } t_bundle;

endpackage

// File: rtl/core/b64d_if.sv
// ----------------------------------------------------------------------------
// b64d_if
// Valid/ready channels: encoded characters in, decoded results out.
// ----------------------------------------------------------------------------
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_data;
    logic       end_of_message;
    logic [2:0] status;

    modport source (output valid, output data_byte, output has_data,
                    output end_of_message, output status, input ready);
    modport sink   (input valid, input data_byte, input has_data,
                    input end_of_message, input status, output ready);
endinterface

// File: rtl/core/base64_decoder_with_validation.sv
// ----------------------------------------------------------------------------
// base64_decoder_with_validation
// Streaming base64 decoder with validation and a per-message status.
// ----------------------------------------------------------------------------
// Input channel: one character per item, last marks the message's final
// character. Output channel: one result per item, either a decoded byte
// (has_data 1, status 0) or a status-only result (has_data 0). The final
// result of every message carries end_of_message; a nonzero status there
// means the whole message is to be discarded.
// Throughput: one character per cycle. A full group of four characters
// yields three bytes, so the output runs at up to one result per cycle and
// averages 0.75. Results of an item pass through a bundle queue of
// P_FIFO_DEPTH entries; input ready drops only while that queue is full.
// Path: an accepted item's bundle is written into the queue at the edge
// at which the item is accepted; its results then pass one at a time into
// the output register, one per cycle while the receiver takes them.
// Reset clears group state, queue pointers and output valid; no result is valid.
// When the receiver stalls, the output register holds its result, the
// queue fills, and input ready then drops until a queued item is popped.
// ----------------------------------------------------------------------------
module base64_decoder_with_validation #(
    parameter int P_FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b64d_in_if.sink    i_in,
    b64d_out_if.source o_out
);
    import b64d_pkg::*;

    t_bundle push_bundle, head;
    logic    push, pop, empty, full;

    b64d_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_queue_full (full),
        .o_push       (push),
        .o_bundle     (push_bundle)
    );

    b64d_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_empty  (empty),
        .o_full   (full)
    );

    b64d_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// File: rtl/core/b64d_decode.sv
// ----------------------------------------------------------------------------
// b64d_decode
// Group state, character decode and validation; builds one result bundle
// per accepted item that causes results.
// ----------------------------------------------------------------------------
module b64d_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    b64d_in_if.sink          i_in,
    input  logic             i_queue_full,
    output logic             o_push,
    output b64d_pkg::t_bundle o_bundle
);
    import b64d_pkg::*;

    logic [17:0] r_bits, n_bits;
    logic [1:0]  r_pos, n_pos;
    logic [1:0]  r_pad, n_pad;
    logic [2:0]  r_err, n_err;

    logic            accept;
    logic            sx_ok;
    logic [5:0]      sx_val;
    logic [7:0]      diff;
    logic            is_pad;
    logic [1:0]      nbytes;
    logic [2:0][7:0] bytes;
    logic [2:0]      fin_err;
    logic            has_data;

    assign i_in.ready = !i_queue_full;
    assign accept     = i_in.valid && i_in.ready;
    assign is_pad     = (i_in.character == PAD_CHAR);

    always_comb begin
        sx_ok = 1'b1;
        diff  = 8'd0;
        if (i_in.character >= 8'h41 && i_in.character <= 8'h5A) begin
            diff = i_in.character - 8'h41;
        end else if (i_in.character >= 8'h61 && i_in.character <= 8'h7A) begin
            diff = i_in.character - 8'h61 + 8'd26;
        end else if (i_in.character >= 8'h30 && i_in.character <= 8'h39) begin
            diff = i_in.character - 8'h30 + 8'd52;
        end else if (i_in.character == 8'h2B) begin
            diff = 8'd62;
        end else if (i_in.character == 8'h2F) begin
            diff = 8'd63;
        end else begin
            sx_ok = 1'b0;
        end
        sx_val = diff[5:0];
    end

    always_comb begin
        n_bits = r_bits;
        n_pos  = r_pos;
        n_pad  = r_pad;
        n_err  = r_err;
        nbytes = 2'd0;
        bytes  = '0;
        if (r_err == ST_OK) begin
            if (sx_ok) begin
                if (r_pad != 2'd0) begin
                    n_err = ST_MISPLACED_PAD;
                end else if (r_pos != 2'd3) begin
                    n_bits = {r_bits[11:0], sx_val};
                    n_pos  = r_pos + 2'd1;
                end else begin
                    bytes[0] = r_bits[17:10];
                    bytes[1] = r_bits[9:2];
                    bytes[2] = {r_bits[1:0], sx_val};
                    nbytes   = 2'd3;
                    n_bits   = '0;
                    n_pos    = 2'd0;
                end
            end else if (is_pad) begin
                case (r_pos)
                    2'd0: begin
                        n_err = (r_pad != 2'd0) ? ST_TOO_MUCH_PAD : ST_MISPLACED_PAD;
                    end
                    2'd1: begin
                        n_err = ST_TOO_MUCH_PAD;
                    end
                    2'd2: begin
                        if (r_bits[3:0] != 4'd0) begin
                            n_err = ST_TRAIL_BITS;
                        end else begin
                            n_pad = 2'd1;
                            n_pos = 2'd3;
                        end
                    end
                    default: begin
                        if (r_pad == 2'd0) begin
                            if (r_bits[1:0] != 2'd0) begin
                                n_err = ST_TRAIL_BITS;
                            end else begin
                                bytes[0] = r_bits[17:10];
                                bytes[1] = r_bits[9:2];
                                nbytes   = 2'd2;
                                n_pad    = 2'd1;
                                n_bits   = '0;
                                n_pos    = 2'd0;
                            end
                        end else begin
                            bytes[0] = r_bits[11:4];
                            nbytes   = 2'd1;
                            n_pad    = 2'd2;
                            n_bits   = '0;
                            n_pos    = 2'd0;
                        end
                    end
                endcase
            end else begin
                n_err = ST_BAD_CHAR;
            end
        end

        fin_err = n_err;
        if (i_in.last && n_err == ST_OK && n_pos != 2'd0) begin
            fin_err = ST_BAD_LENGTH;
        end
        has_data = (fin_err == ST_OK) && (nbytes != 2'd0);

        o_push            = accept && (has_data || i_in.last);
        o_bundle.bytes    = has_data ? bytes : '0;
        o_bundle.last_idx = has_data ? nbytes - 2'd1 : 2'd0;
        o_bundle.has_data = has_data;
        o_bundle.eom      = i_in.last;
        o_bundle.status   = has_data ? ST_OK : fin_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_pos  <= '0;
            r_pad  <= '0;
            r_err  <= ST_OK;
        end else if (accept) begin
            if (i_in.last) begin
                r_bits <= '0;
                r_pos  <= '0;
                r_pad  <= '0;
                r_err  <= ST_OK;
            end else begin
                r_bits <= n_bits;
                r_pos  <= n_pos;
                r_pad  <= n_pad;
                r_err  <= n_err;
            end
        end
    end

endmodule

// File: rtl/core/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo
// Small queue of result bundles between the decoder and the output stage.
// ----------------------------------------------------------------------------
module b64d_fifo #(
    parameter int P_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64d_pkg::t_bundle i_bundle,
    input  logic              i_pop,
    output b64d_pkg::t_bundle o_head,
    output logic              o_empty,
    output logic              o_full
);
    import b64d_pkg::*;

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    t_bundle       r_mem [P_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/core/b64d_unpack.sv
// ----------------------------------------------------------------------------
// b64d_unpack
// Walk the head bundle one result at a time into the output register.
// ----------------------------------------------------------------------------
module b64d_unpack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b64d_pkg::t_bundle i_head,
    input  logic              i_empty,
    output logic              o_pop,
    b64d_out_if.source        o_out
);
    import b64d_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_has;
    logic       r_eom;
    logic [2:0] r_status;
    logic [1:0] r_idx;
    logic       load, take, at_end;

    assign load   = !r_valid || o_out.ready;
    assign take   = load && !i_empty;
    assign at_end = (r_idx == i_head.last_idx);
    assign o_pop  = take && at_end;

    assign o_out.valid          = r_valid;
    assign o_out.data_byte      = r_byte;
    assign o_out.has_data       = r_has;
    assign o_out.end_of_message = r_eom;
    assign o_out.status         = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (take) begin
                r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte   <= i_head.bytes[r_idx];
            r_has    <= i_head.has_data;
            r_eom    <= i_head.eom && at_end;
            r_status <= i_head.status;
        end
    end

endmodule

// File: rtl/core/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
module b64d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_data_byte,
    input logic       i_has_data,
    input logic       i_eom,
    input logic [2:0] i_status
);
    import b64d_pkg::*;

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_has_data |-> i_status == ST_OK)
        else $error("data result with nonzero status");

    a_status_eom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_has_data |-> i_eom && i_data_byte == 8'd0)
        else $error("status-only result not at end of message");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status <= ST_BAD_LENGTH)
        else $error("status code out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_byte)
            && $stable(i_has_data) && $stable(i_eom) && $stable(i_status))
        else $error("stalled result changed");

endmodule

bind base64_decoder_with_validation b64d_checker u_b64d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_data_byte (o_out.data_byte),
    .i_has_data  (o_out.has_data),
    .i_eom       (o_out.end_of_message),
    .i_status    (o_out.status)
);
